// File: rtl/core/alusf_pkg.sv
// types, operation codes and helpers for the 6502-style accumulator and flag unit
// no dependencies; used by alusf_exec and cpu_alu_and_status_flags
`default_nettype none

package alusf_pkg;

    localparam logic [4:0] OP_ORA = 5'd0;
    localparam logic [4:0] OP_AND = 5'd1;
    localparam logic [4:0] OP_EOR = 5'd2;
    localparam logic [4:0] OP_ADC = 5'd3;
    localparam logic [4:0] OP_ASL = 5'd4;
    localparam logic [4:0] OP_LSR = 5'd5;
    localparam logic [4:0] OP_ROL = 5'd6;
    localparam logic [4:0] OP_ROR = 5'd7;
    localparam logic [4:0] OP_BIT = 5'd8;
    localparam logic [4:0] OP_CLC = 5'd9;
    localparam logic [4:0] OP_SEC = 5'd10;
    localparam logic [4:0] OP_CLI = 5'd11;
    localparam logic [4:0] OP_SEI = 5'd12;
    localparam logic [4:0] OP_PHP = 5'd13;
    localparam logic [4:0] OP_PLP = 5'd14;
    localparam logic [4:0] OP_PHA = 5'd15;
    localparam logic [4:0] OP_PLA = 5'd16;
    localparam logic [4:0] OP_BRANCH = 5'd17;
    localparam logic [4:0] OP_INTERRUPT = 5'd18;

    localparam logic [1:0] BR_N_CLEAR = 2'd0;
    localparam logic [1:0] BR_N_SET = 2'd1;
    localparam logic [1:0] BR_V_CLEAR = 2'd2;
    localparam logic [1:0] BR_V_SET = 2'd3;

    localparam logic [7:0] STATUS_FIXED_BITS = 8'h30;
    localparam logic [7:0] HW_BREAK_MASK = 8'hef;

    typedef struct packed {
        logic [4:0] operation;
        logic [7:0] operand;
        logic       on_accumulator;
        logic [1:0] branch_kind;
        logic       break_source;
    } alusf_item_t;

    typedef struct packed {
        logic n;
        logic v;
        logic d;
        logic i;
        logic z;
        logic c;
    } alusf_flags_t;

    typedef struct packed {
        logic [7:0]   acc;
        alusf_flags_t flags;
    } alusf_state_t;

    typedef struct packed {
        logic [7:0] result_byte;
        logic [7:0] status_byte;
        logic       branch_taken;
    } alusf_result_t;

    function automatic logic [7:0] pack_status(input alusf_flags_t f);
        pack_status = STATUS_FIXED_BITS
                    | {f.n, f.v, 2'b00, f.d, f.i, f.z, f.c};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/alusf_exec.sv
// single-pass operation logic: next accumulator, next flags and result word
// depends on alusf_pkg
`default_nettype none

module alusf_exec (
    input  var alusf_pkg::alusf_state_t  cur,
    input  var alusf_pkg::alusf_item_t   item,
    output alusf_pkg::alusf_state_t      nxt,
    output alusf_pkg::alusf_result_t     res
);
    import alusf_pkg::*;

    logic [7:0] src;
    logic [7:0] shifted;
    logic       shift_carry;
    logic [8:0] sum;
    logic [7:0] logic_val;
    logic [7:0] status_now;

    assign src        = item.on_accumulator ? cur.acc : item.operand;
    assign sum        = {1'b0, cur.acc} + {1'b0, item.operand} + {8'd0, cur.flags.c};
    assign status_now = pack_status(cur.flags);

    always_comb
    begin
        case (item.operation)
            OP_ASL:
            begin
                shifted     = {src[6:0], 1'b0};
                shift_carry = src[7];
            end
            OP_LSR:
            begin
                shifted     = {1'b0, src[7:1]};
                shift_carry = src[0];
            end
            OP_ROL:
            begin
                shifted     = {src[6:0], cur.flags.c};
                shift_carry = src[7];
            end
            default:
            begin
                shifted     = {cur.flags.c, src[7:1]};
                shift_carry = src[0];
            end
        endcase
    end

    always_comb
    begin
        case (item.operation)
            OP_ORA:  logic_val = cur.acc | item.operand;
            OP_AND:  logic_val = cur.acc & item.operand;
            OP_EOR:  logic_val = cur.acc ^ item.operand;
            OP_ADC:  logic_val = sum[7:0];
            default: logic_val = item.operand;
        endcase
    end

    always_comb
    begin
        nxt              = cur;
        res.result_byte  = cur.acc;
        res.branch_taken = 1'b0;
        case (item.operation)
            OP_ORA, OP_AND, OP_EOR, OP_PLA:
            begin
                nxt.acc         = logic_val;
                nxt.flags.n     = logic_val[7];
                nxt.flags.z     = (logic_val == 8'd0);
                res.result_byte = logic_val;
            end
            OP_ADC:
            begin
                nxt.acc         = logic_val;
                nxt.flags.n     = logic_val[7];
                nxt.flags.z     = (logic_val == 8'd0);
                // operands agree in sign, sum does not
                nxt.flags.v     = ~(cur.acc[7] ^ item.operand[7]) & (cur.acc[7] ^ logic_val[7]);
                nxt.flags.c     = sum[8];
                res.result_byte = logic_val;
            end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR:
            begin
                nxt.flags.c     = shift_carry;
                nxt.flags.n     = shifted[7];
                nxt.flags.z     = (shifted == 8'd0);
                res.result_byte = shifted;
                if (item.on_accumulator)
                begin
                    nxt.acc = shifted;
                end
            end
            OP_BIT:
            begin
                nxt.flags.n = item.operand[7];
                nxt.flags.v = item.operand[6];
                nxt.flags.z = ((cur.acc & item.operand) == 8'd0);
            end
            OP_CLC: nxt.flags.c = 1'b0;
            OP_SEC: nxt.flags.c = 1'b1;
            OP_CLI: nxt.flags.i = 1'b0;
            OP_SEI: nxt.flags.i = 1'b1;
            OP_PHP: res.result_byte = status_now;
            OP_PLP:
            begin
                nxt.flags.n = item.operand[7];
                nxt.flags.v = item.operand[6];
                nxt.flags.d = item.operand[3];
                nxt.flags.i = item.operand[2];
                nxt.flags.z = item.operand[1];
                nxt.flags.c = item.operand[0];
            end
            OP_BRANCH:
            begin
                case (item.branch_kind)
                    BR_N_CLEAR: res.branch_taken = ~cur.flags.n;
                    BR_N_SET:   res.branch_taken = cur.flags.n;
                    BR_V_CLEAR: res.branch_taken = ~cur.flags.v;
                    BR_V_SET:   res.branch_taken = cur.flags.v;
                    default:    res.branch_taken = 1'b0;
                endcase
            end
            OP_INTERRUPT:
            begin
                // pushed status is taken before i is set
                res.result_byte = item.break_source ? status_now
                                                    : (status_now & HW_BREAK_MASK);
                nxt.flags.i     = 1'b1;
            end
            default:
            begin
                res.result_byte = cur.acc;
            end
        endcase
        res.status_byte = pack_status(nxt.flags);
    end

endmodule

`default_nettype wire

// File: rtl/core/cpu_alu_and_status_flags.sv
// top level of the 6502-style accumulator and status-flag unit
// depends on alusf_pkg and alusf_exec
`default_nettype none

// Binary-mode 6502 accumulator and flag unit. One operation word enters per clock
// unless the output stalls; its result word passes the input register, then the
// result register, and the unit sustains one word per cycle when not stalled, since
// every operation is a single pass of 8-bit logic between those two registers. A and
// the flags update in the same edge that loads the result register, so back-to-back
// words see each other's effects. Decimal mode is not implemented: D is only stored
// and reported. After reset A is zero and only the I flag is set.
module cpu_alu_and_status_flags (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // operation[4:0], operand[12:5], on_accumulator[13], branch_kind[15:14],
    // break_source[16], zero[23:17]
    input  wire logic [23:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // result_byte[7:0], status_byte[15:8], branch_taken[16], zero[23:17]
    output logic [23:0]      m_tdata
);
    import alusf_pkg::*;

    logic          in_valid_reg;
    alusf_item_t   in_item_reg;
    logic          out_valid_reg;
    logic [23:0]   out_data_reg;
    alusf_state_t  state_reg;
    alusf_state_t  state_next;
    alusf_result_t res;
    logic          advance;
    alusf_item_t   s_item;

    assign s_item.operation      = s_tdata[4:0];
    assign s_item.operand        = s_tdata[12:5];
    assign s_item.on_accumulator = s_tdata[13];
    assign s_item.branch_kind    = s_tdata[15:14];
    assign s_item.break_source   = s_tdata[16];

    // input stage moves on whenever the result register is free or draining
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | ~out_valid_reg | m_tready;

    alusf_exec u_exec (
        .cur  (state_reg),
        .item (in_item_reg),
        .nxt  (state_next),
        .res  (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{acc: 8'd0,
                               flags: '{n: 1'b0, v: 1'b0, d: 1'b0,
                                        i: 1'b1, z: 1'b0, c: 1'b0}};
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= s_item;
        end
        if (advance)
        begin
            out_data_reg <= {7'd0, res.branch_taken, res.status_byte, res.result_byte};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/alusf_checker.sv
// port-level checks for cpu_alu_and_status_flags, attached by bind
// no package dependencies
`default_nettype none

module alusf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // status bits 5 and 4 always read as one
    a_fixed_bits: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[13] && m_tdata[12]))
        else $error("status fixed bits not set");

    // a ready consumer never stalls the input side
    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("output word changed while stalled");

    // once an accepted word has passed the input register, the output holds a valid word
    a_word_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> ##1 m_tvalid)
        else $error("accepted word did not reach the output");

endmodule

bind cpu_alu_and_status_flags alusf_checker u_alusf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
